@@ src/sobel_pkg.sv @@
// Shared constants and register codes for the Sobel edge threshold stream core.
`timescale 1ns / 1ps
`default_nettype none
package sobel_pkg;

	localparam int PIX_W      = 8;
	localparam int WIDTH_W    = 10;
	localparam int HEIGHT_W   = 12;
	localparam int THR_W      = 11;
	localparam int MAG_W      = 11;
	localparam int ABS_W      = 10;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 2;

	localparam int DEF_MAX_LINE_WIDTH = 512;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

	localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH    = 10'd320;
	localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT   = 12'd240;
	localparam logic [THR_W-1:0]    RST_EDGE_THRESHOLD = 11'd128;

	localparam logic [HEIGHT_W-1:0] MIN_DIM = 12'd3;

	localparam logic [PIX_W-1:0] EDGE_ON  = 8'hFF;
	localparam logic [PIX_W-1:0] EDGE_OFF = 8'h00;

endpackage
`default_nettype wire

@@ src/sobel_line_mem.sv @@
// Two-line pixel buffer: one synchronous memory holding {line above, line two above}.
`timescale 1ns / 1ps
`default_nettype none
module sobel_line_mem
	import sobel_pkg::*;
#(
	parameter int MaxLineWidth = DEF_MAX_LINE_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            rd_en,
	input  wire logic [$clog2(MaxLineWidth)-1:0] rd_addr,
	output logic      [2*PIX_W-1:0]              rd_data,
	input  wire logic                            wr_en,
	input  wire logic [$clog2(MaxLineWidth)-1:0] wr_addr,
	input  wire logic [2*PIX_W-1:0]              wr_data
);

	logic [2*PIX_W-1:0] mem [MaxLineWidth];
	logic [2*PIX_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire

@@ src/sobel_edge_threshold_stream_core.sv @@
// Top level: streaming 3x3 Sobel edge detector with L1 magnitude and threshold.
//
// Takes one 8-bit pixel per clock in raster order while in_stall is low and
// returns one word per interior pixel (one line up, one column left of the
// pixel just taken); border positions give no word. Sustained rate is one
// pixel per clock when out_stall is low, set by the line memory, which can
// serve a read and a write together. The pipeline collapses bubbles, so
// input keeps flowing while a finished word waits on out_stall until every
// stage is full. Line memory contents are undefined after reset and need no
// clearing; image_width, image_height and edge_threshold may only be written
// while the core is idle.
`timescale 1ns / 1ps
`default_nettype none
module sobel_edge_threshold_stream_core
	import sobel_pkg::*;
#(
	parameter int MaxLineWidth = DEF_MAX_LINE_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [PIX_W-1:0]      pixel,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic      [PIX_W-1:0]      edge_res,
	output logic      [MAG_W-1:0]      magnitude,
	output logic                       frame_last
);

	localparam int ColW = $clog2(MaxLineWidth);
	localparam int LW   = (ColW >= WIDTH_W) ? ColW + 1 : WIDTH_W + 1;
	localparam int SumW = ABS_W;

	function automatic logic [ABS_W-1:0] abs_grad(
		input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c,
		input logic [PIX_W-1:0] d, input logic [PIX_W-1:0] e, input logic [PIX_W-1:0] f
	);
		logic [SumW-1:0]   sp;
		logic [SumW-1:0]   sn;
		logic signed [SumW:0] diff;
		sp   = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
		sn   = {2'b00, d} + {1'b0, e, 1'b0} + {2'b00, f};
		diff = $signed({1'b0, sp}) - $signed({1'b0, sn});
		abs_grad = diff[SumW] ? ABS_W'(-diff) : ABS_W'(diff);
	endfunction

	// configuration
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [THR_W-1:0]    thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			thr_q    <= RST_EDGE_THRESHOLD;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:    width_q  <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT:   height_q <= cfg_data[HEIGHT_W-1:0];
				REG_EDGE_THRESHOLD: thr_q    <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// stage control
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic en_o, en3, en2, en1;
	logic accept;
	logic s1_go;

	assign en_o   = !out_valid_q || !out_stall;
	assign en3    = !v_s3 || en_o;
	assign en2    = !v_s2 || en3;
	assign en1    = !v_s1 || en2;
	assign in_stall = !en1;
	assign accept = in_valid && en1;
	assign s1_go  = v_s1 && en2;

	// position counters
	logic [ColW-1:0]     col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [LW-1:0]       w_raw;
	logic [LW-1:0]       w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic [LW-1:0]       col_inc;
	logic [HEIGHT_W:0]   row_inc;
	logic                line_end;
	logic                frame_end;
	logic                emit;

	always_comb begin
		w_raw = LW'(width_q);
		if (w_raw < LW'(MIN_DIM)) begin
			w_eff = LW'(MIN_DIM);
		end else if (w_raw > LW'(MaxLineWidth)) begin
			w_eff = LW'(MaxLineWidth);
		end else begin
			w_eff = w_raw;
		end
		h_eff     = (height_q < MIN_DIM) ? MIN_DIM : height_q;
		col_inc   = LW'(col_q) + LW'(1);
		row_inc   = {1'b0, row_q} + (HEIGHT_W+1)'(1);
		line_end  = col_inc >= w_eff;
		frame_end = line_end && (row_inc >= {1'b0, h_eff});
		emit      = (LW'(col_q) >= LW'(2)) && (row_q >= HEIGHT_W'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (line_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_inc[HEIGHT_W-1:0];
			end else begin
				col_q <= col_inc[ColW-1:0];
			end
		end
	end

	// stage 1: line memory read in flight
	logic [PIX_W-1:0]   px_s1;
	logic [ColW-1:0]    col_s1;
	logic               emit_s1;
	logic               fl_s1;
	logic [2*PIX_W-1:0] mem_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= pixel;
			col_s1  <= col_q;
			emit_s1 <= emit;
			fl_s1   <= frame_end;
		end
	end

	// consecutive words never touch the same entry, so no forwarding is needed
	sobel_line_mem #(
		.MaxLineWidth(MaxLineWidth)
	) u_line_mem (
		.clk    (clk),
		.rd_en  (accept),
		.rd_addr(col_q),
		.rd_data(mem_rd),
		.wr_en  (s1_go),
		.wr_addr(col_s1),
		.wr_data({px_s1, mem_rd[2*PIX_W-1:PIX_W]})
	);

	// stage 2: window holds the item in s2
	logic [PIX_W-1:0] win_q [9];
	logic             fl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_go) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]   <= win_q[r*3+1];
				win_q[r*3+1] <= win_q[r*3+2];
			end
			win_q[2] <= mem_rd[PIX_W-1:0];
			win_q[5] <= mem_rd[2*PIX_W-1:PIX_W];
			win_q[8] <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			fl_s2 <= fl_s1;
		end
	end

	// stage 3: gradient magnitudes
	logic [ABS_W-1:0] absx_s3;
	logic [ABS_W-1:0] absy_s3;
	logic             fl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			absx_s3 <= abs_grad(win_q[2], win_q[5], win_q[8], win_q[0], win_q[3], win_q[6]);
			absy_s3 <= abs_grad(win_q[0], win_q[1], win_q[2], win_q[6], win_q[7], win_q[8]);
			fl_s3   <= fl_s2;
		end
	end

	// output register
	logic [MAG_W-1:0] mag_sum;
	logic [PIX_W-1:0] edge_q;
	logic [MAG_W-1:0] mag_q;
	logic             fl_q;

	assign mag_sum = MAG_W'(absx_s3) + MAG_W'(absy_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_o) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && v_s3) begin
			mag_q  <= mag_sum;
			edge_q <= (mag_sum > thr_q) ? EDGE_ON : EDGE_OFF;
			fl_q   <= fl_s3;
		end
	end

	assign out_valid  = out_valid_q;
	assign edge_res   = edge_q;
	assign magnitude  = mag_q;
	assign frame_last = fl_q;

	// checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && out_valid_q))
		else $error("input stalled with an empty stage");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= HEIGHT_W'(4094))
		else $error("row counter beyond frame bound");

	a_mem_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s1_go) |-> (col_q != col_s1))
		else $error("line memory read and write hit the same entry");

	a_emit_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s2) |-> $past(v_s1))
		else $error("window stage loaded without a source word");

endmodule
`default_nettype wire

@@ test/sobel_edge_threshold_stream_core_test.sv @@
// Self-checking testbench for the Sobel edge threshold stream core.
`timescale 1ns / 1ps
module sobel_edge_threshold_stream_core_test
	import sobel_pkg::*;
();

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int TOTAL_ITEMS    = 1450;
	localparam int CALM_ITEMS     = 250;
	localparam int DIRECTED_ITEMS = 2*9 + 2*DEF_MAX_LINE_WIDTH + 8;
	localparam int DRAIN_CYCLES   = 12;
	localparam int HOLD_CYCLES    = 80;
	localparam int CYCLE_LIMIT    = 500000;
	localparam logic [PIX_W-1:0] CORNER_FRAME [9] = '{
		8'd0, 8'd255, 8'd255,
		8'd0, 8'd0,   8'd255,
		8'd0, 8'd0,   8'd0
	};

	typedef enum int {PIX_UNIFORM, PIX_BINARY, PIX_SMOOTH} pix_mode_t;

	typedef struct {
		logic [PIX_W-1:0] edge_res;
		logic [MAG_W-1:0] magnitude;
		logic             frame_last;
	} edge_word_t;

	class edge_scoreboard_t;
		logic [WIDTH_W-1:0]  width_reg;
		logic [HEIGHT_W-1:0] height_reg;
		logic [THR_W-1:0]    thr_reg;
		logic [PIX_W-1:0]    line_above [DEF_MAX_LINE_WIDTH];
		logic [PIX_W-1:0]    line_two_above [DEF_MAX_LINE_WIDTH];
		logic [PIX_W-1:0]    win [9];
		int unsigned         col_cnt;
		int unsigned         row_cnt;
		edge_word_t          expected_edges [$];
		int                  errors;

		function new();
			width_reg  = RST_IMAGE_WIDTH;
			height_reg = RST_IMAGE_HEIGHT;
			thr_reg    = RST_EDGE_THRESHOLD;
			foreach (line_above[i]) begin
				line_above[i]     = '0;
				line_two_above[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			col_cnt = 0;
			row_cnt = 0;
			errors  = 0;
		endfunction

		function int unsigned eff_width_of(input logic [CFG_DATA_W-1:0] raw);
			int unsigned w;
			w = 32'(raw[WIDTH_W-1:0]);
			if (w < 3) w = 3;
			if (w > DEF_MAX_LINE_WIDTH) w = DEF_MAX_LINE_WIDTH;
			return w;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_IMAGE_WIDTH: begin
					width_reg = val[WIDTH_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					height_reg = val[HEIGHT_W-1:0];
				end
				REG_EDGE_THRESHOLD: begin
					thr_reg = val[THR_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function void note_pixel(input logic [PIX_W-1:0] px);
			int unsigned w, h;
			int gx, gy, mag;
			logic [PIX_W-1:0] up, up2;
			logic line_end, frame_end;
			edge_word_t word;
			w = eff_width_of(CFG_DATA_W'(width_reg));
			h = (height_reg < 3) ? 3 : 32'(height_reg);
			up = '0;
			up2 = '0;
			if (col_cnt < DEF_MAX_LINE_WIDTH) begin
				up = line_above[col_cnt];
				up2 = line_two_above[col_cnt];
				line_two_above[col_cnt] = up;
				line_above[col_cnt] = px;
			end
			for (int r = 0; r < 3; r++) begin
				win[r*3]   = win[r*3+1];
				win[r*3+1] = win[r*3+2];
			end
			win[2] = up2;
			win[5] = up;
			win[8] = px;
			line_end = (col_cnt + 1 >= w);
			frame_end = line_end && (row_cnt + 1 >= h);
			if (col_cnt >= 2 && row_cnt >= 2) begin
				gx = (int'(win[2]) + 2*int'(win[5]) + int'(win[8]))
					- (int'(win[0]) + 2*int'(win[3]) + int'(win[6]));
				gy = (int'(win[0]) + 2*int'(win[1]) + int'(win[2]))
					- (int'(win[6]) + 2*int'(win[7]) + int'(win[8]));
				mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
				word.edge_res = (mag > int'(thr_reg)) ? EDGE_ON : EDGE_OFF;
				word.magnitude = mag[MAG_W-1:0];
				word.frame_last = frame_end;
				expected_edges.push_back(word);
			end
			if (line_end) begin
				col_cnt = 0;
				row_cnt = frame_end ? 0 : ((row_cnt + 1) & 32'hFFF);
			end else begin
				col_cnt = col_cnt + 1;
			end
		endfunction

		function void check_word(input edge_word_t got);
			edge_word_t want;
			if (expected_edges.size() == 0) begin
				$error("word with none expected: edge_res %0d magnitude %0d frame_last %0d",
					got.edge_res, got.magnitude, got.frame_last);
				errors++;
				return;
			end
			want = expected_edges.pop_front();
			if (got.edge_res !== want.edge_res) begin
				$error("edge_res: expected %0d, got %0d", want.edge_res, got.edge_res);
				errors++;
			end
			if (got.magnitude !== want.magnitude) begin
				$error("magnitude: expected %0d, got %0d", want.magnitude, got.magnitude);
				errors++;
			end
			if (got.frame_last !== want.frame_last) begin
				$error("frame_last: expected %0d, got %0d", want.frame_last, got.frame_last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_edges.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [PIX_W-1:0]      pixel;
	logic                  out_valid;
	logic                  out_stall;
	logic [PIX_W-1:0]      edge_res;
	logic [MAG_W-1:0]      magnitude;
	logic                  frame_last;

	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	bit long_hold = 1'b0;

	edge_scoreboard_t sb = new();

	sobel_edge_threshold_stream_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel      (pixel),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.edge_res   (edge_res),
		.magnitude  (magnitude),
		.frame_last (frame_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin : monitor
		edge_word_t got;
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_pixel(pixel);
			if (out_valid && !out_stall) begin
				got.edge_res = edge_res;
				got.magnitude = magnitude;
				got.frame_last = frame_last;
				sb.check_word(got);
			end
		end
	end

	initial begin : receiver
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
				out_stall = 1'b0;
			end else if (rx_idle && $urandom_range(0, 7) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	// leaves valid high on return so back-to-back words need no toggle
	task automatic send_pixel(input logic [PIX_W-1:0] p);
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_valid = 1'b1;
		pixel = p;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_phase(input int count, input pix_mode_t mode);
		logic [PIX_W-1:0] base, p;
		base = PIX_W'($urandom);
		for (int i = 0; i < count; i++) begin
			case (mode)
				PIX_BINARY: p = $urandom_range(0, 1) ? EDGE_ON : EDGE_OFF;
				PIX_SMOOTH: p = base + PIX_W'($urandom_range(0, 7));
				default:    p = PIX_W'($urandom);
			endcase
			send_pixel(p);
		end
	endtask

	// border pixels leave no word behind, so give the pipe time to empty
	task automatic wait_idle();
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		int phase_idx, count, items;
		int unsigned cur_w, new_w, new_h;
		bit mid_frame;
		logic [CFG_DATA_W-1:0] wv, hv, tv;
		pix_mode_t mode;

		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// corner pattern gives the largest magnitude, 1530
		write_reg(REG_IMAGE_WIDTH, 12'd3);
		write_reg(REG_IMAGE_HEIGHT, 12'd3);
		write_reg(REG_EDGE_THRESHOLD, 12'd1529);
		foreach (CORNER_FRAME[i]) send_pixel(CORNER_FRAME[i]);
		wait_idle();
		// sizes below 3 clamp up; threshold equal to magnitude is no edge
		write_reg(REG_IMAGE_WIDTH, 12'd0);
		write_reg(REG_IMAGE_HEIGHT, 12'd1);
		write_reg(REG_EDGE_THRESHOLD, 12'd1530);
		write_reg(REG_UNUSED, 12'hFFF);
		foreach (CORNER_FRAME[i]) send_pixel(CORNER_FRAME[i]);
		wait_idle();

		// widest line: width above the line memory saturates
		write_reg(REG_IMAGE_WIDTH, 12'd1023);
		write_reg(REG_IMAGE_HEIGHT, 12'd3);
		write_reg(REG_EDGE_THRESHOLD, 12'd400);
		send_phase(2*DEF_MAX_LINE_WIDTH + 8, PIX_UNIFORM);
		wait_idle();

		items = DIRECTED_ITEMS;
		phase_idx = 0;
		while (items < TOTAL_ITEMS) begin
			if (items >= TOTAL_ITEMS - CALM_ITEMS) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end
			cur_w = sb.eff_width_of(CFG_DATA_W'(sb.width_reg));
			mid_frame = (sb.col_cnt != 0) || (sb.row_cnt != 0);
			case ($urandom_range(0, 7))
				0: wv = CFG_DATA_W'($urandom_range(0, 2));
				1: wv = CFG_DATA_W'($urandom);
				default: wv = CFG_DATA_W'($urandom_range(3, 12));
			endcase
			// widening mid-frame would read line memory never written
			if (mid_frame && sb.eff_width_of(wv) > cur_w)
				wv = CFG_DATA_W'($urandom_range(0, cur_w));
			case ($urandom_range(0, 7))
				0: hv = CFG_DATA_W'($urandom_range(0, 2));
				1: hv = CFG_DATA_W'($urandom);
				default: hv = CFG_DATA_W'($urandom_range(3, 8));
			endcase
			case ($urandom_range(0, 9))
				0: tv = 12'd0;
				1: tv = 12'd2040;
				2: tv = 12'd2047;
				3: tv = CFG_DATA_W'($urandom);
				default: tv = CFG_DATA_W'($urandom_range(0, 700));
			endcase
			if (phase_idx == 0) begin
				wv = 12'd3;
				hv = 12'd40;
			end
			write_reg(REG_IMAGE_WIDTH, wv);
			write_reg(REG_IMAGE_HEIGHT, hv);
			write_reg(REG_EDGE_THRESHOLD, tv);
			if ($urandom_range(0, 5) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));

			new_w = sb.eff_width_of(wv);
			new_h = (hv < 3) ? 3 : 32'(hv);
			if ($urandom_range(0, 5) == 0 || new_w * new_h > 150)
				count = $urandom_range(1, 60);
			else
				count = new_w * new_h * $urandom_range(1, 3);
			if (phase_idx == 0) count = 100;
			if (items < TOTAL_ITEMS - CALM_ITEMS && items + count > TOTAL_ITEMS - CALM_ITEMS)
				count = TOTAL_ITEMS - CALM_ITEMS - items;
			if (items + count > TOTAL_ITEMS) count = TOTAL_ITEMS - items;
			mode = pix_mode_t'($urandom_range(0, 2));

			if (phase_idx == 0) begin
				// receiver holds off while the sender keeps offering words
				tx_idle = 1'b0;
				long_hold = 1'b1;
				send_phase(count, PIX_UNIFORM);
				tx_idle = 1'b1;
			end else begin
				send_phase(count, mode);
			end
			wait_idle();
			items += count;
			phase_idx++;
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/sobel_pkg.sv
src/sobel_line_mem.sv
src/sobel_edge_threshold_stream_core.sv
test/sobel_edge_threshold_stream_core_test.sv
